>>> hw/rtl/pclim_pkg.sv
// Package for the per-host connection limiter.
// Pool sizing, entry layout, action/status/register codes and shared structs.
// No dependencies.
package pclim_pkg;

  localparam int unsigned POOL_ENTRIES = 64;
  localparam int unsigned IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned USED_W = $clog2(POOL_ENTRIES + 1);

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned WIN_W    = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

  localparam logic [WIN_W-1:0]   WINDOW_RESET = 32'd60000;
  localparam logic [COUNT_W-1:0] LIMIT_RESET  = 16'd10;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  start;
  } entry_t;

  typedef struct packed {
    logic match;
    logic expired;
  } cmp_res_t;

endpackage

>>> hw/rtl/pclim_if.sv
// Request and response channel interfaces of the connection limiter.
// Depends on pclim_pkg.
interface pclim_req_if;
  logic                             valid;
  logic                             ready;
  logic [pclim_pkg::ACTION_W-1:0]   action;
  logic [pclim_pkg::ADDR_W-1:0]     host;
  logic [pclim_pkg::TIME_W-1:0]     now_ms;

  modport source (output valid, action, host, now_ms, input ready);
  modport sink   (input valid, action, host, now_ms, output ready);
endinterface

interface pclim_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [pclim_pkg::STATUS_W-1:0]   status;
  logic                             is_blocked;
  logic [pclim_pkg::COUNT_W-1:0]    host_count;

  modport source (output valid, status, is_blocked, host_count, input ready);
  modport sink   (input valid, status, is_blocked, host_count, output ready);
endinterface

>>> hw/rtl/pclim_store.sv
// Host entry memory: one write port, one read port with registered data.
// Depends on pclim_pkg.
module pclim_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [pclim_pkg::IDX_W-1:0] waddr_i,
  input  pclim_pkg::entry_t          wdata_i,
  input  logic [pclim_pkg::IDX_W-1:0] raddr_i,
  output pclim_pkg::entry_t          rdata_o
);

  pclim_pkg::entry_t mem_q [pclim_pkg::POOL_ENTRIES];
  pclim_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/pclim_cmp.sv
// Shared compare unit: host address match and window expiry of one entry.
// Depends on pclim_pkg.
module pclim_cmp (
  input  logic [pclim_pkg::ADDR_W-1:0] host_i,
  input  logic [pclim_pkg::TIME_W-1:0] now_i,
  input  logic [pclim_pkg::WIN_W-1:0]  window_i,
  input  pclim_pkg::entry_t            entry_i,
  output pclim_pkg::cmp_res_t          res_o
);

  logic [pclim_pkg::TIME_W:0] age;

  // top bit set means time went backwards: never expired
  assign age = {1'b0, now_i} - {1'b0, entry_i.start};

  assign res_o.match   = (entry_i.address == host_i);
  assign res_o.expired = !age[pclim_pkg::TIME_W] &&
      (age[pclim_pkg::TIME_W-1:0] >
       {{(pclim_pkg::TIME_W-pclim_pkg::WIN_W){1'b0}}, window_i});

endmodule

>>> hw/rtl/per_host_connection_limiter.sv
// Top level of the per-host connection limiter: sequencer, config registers
// and response register. Depends on pclim_pkg, pclim_if, pclim_store, pclim_cmp.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        action, host, now_ms
//   rsp_o    out  valid/ready        status, is_blocked, host_count
//   cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// Query and record make one pass of the single memory read port through the
// used entries; clear skips the pass and only empties the pool. Reset empties
// the pool at once (fill count).
// A finished result waits in the response register; a new request is taken
// meanwhile and stalls only at its own end until the register is free.
module per_host_connection_limiter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pclim_req_if.sink                        req_i,
  pclim_rsp_if.source                      rsp_o,
  input  logic                             cfg_we_i,
  input  logic [pclim_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pclim_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int unsigned IW = pclim_pkg::IDX_W;
  localparam int unsigned UW = pclim_pkg::USED_W;
  localparam int unsigned CW = pclim_pkg::COUNT_W;

  logic [1:0] state_q, state_d;

  logic [pclim_pkg::WIN_W-1:0] window_q;
  logic [CW-1:0]               limit_q;

  logic [pclim_pkg::ACTION_W-1:0] act_q;
  logic [pclim_pkg::ADDR_W-1:0]   host_q;
  logic [pclim_pkg::TIME_W-1:0]   now_q;

  logic [UW-1:0] used_q, used_d;
  logic [UW-1:0] rd_idx_q, rd_idx_d;
  logic          chk_vld_q, chk_vld_d;
  logic [IW-1:0] chk_idx_q, chk_idx_d;

  logic          hit_q, hit_d;
  logic          hit_exp_q, hit_exp_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [CW-1:0] hit_cnt_q, hit_cnt_d;
  logic [pclim_pkg::TIME_W-1:0] hit_start_q, hit_start_d;
  logic          exp_q, exp_d;
  logic [IW-1:0] exp_idx_q, exp_idx_d;

  logic [pclim_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [CW-1:0]                  res_count_q, res_count_d;
  logic                           res_blk_q, res_blk_d;

  logic                           rsp_valid_q, rsp_valid_d;
  logic [pclim_pkg::STATUS_W-1:0] rsp_status_q;
  logic [CW-1:0]                  rsp_count_q;
  logic                           rsp_blk_q;

  logic                 we;
  logic [IW-1:0]        waddr;
  pclim_pkg::entry_t    wdata;
  pclim_pkg::entry_t    rdata;
  pclim_pkg::cmp_res_t  cmp_res;

  logic req_fire, rsp_load, full;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign full        = (used_q == UW'(pclim_pkg::POOL_ENTRIES));
  assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  pclim_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q[IW-1:0]),
    .rdata_o (rdata)
  );

  pclim_cmp u_cmp (
    .host_i   (host_q),
    .now_i    (now_q),
    .window_i (window_q),
    .entry_i  (rdata),
    .res_o    (cmp_res)
  );

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    rd_idx_d     = rd_idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    hit_d        = hit_q;
    hit_exp_d    = hit_exp_q;
    hit_idx_d    = hit_idx_q;
    hit_cnt_d    = hit_cnt_q;
    hit_start_d  = hit_start_q;
    exp_d        = exp_q;
    exp_idx_d    = exp_idx_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_blk_d    = res_blk_q;
    we           = 1'b0;
    waddr        = hit_idx_q;
    wdata        = '{address: host_q, count: CW'(1), start: now_q};

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          rd_idx_d = '0;
          hit_d    = 1'b0;
          exp_d    = 1'b0;
          if (req_i.action == pclim_pkg::ACT_CLEAR) begin
            used_d       = '0;
            res_status_d = pclim_pkg::ST_FOUND;
            res_count_d  = '0;
            res_blk_d    = 1'b0;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_q < used_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[IW-1:0];
          rd_idx_d  = rd_idx_q + UW'(1);
        end else if (!chk_vld_q) begin
          state_d = S_UPD;
        end
        if (chk_vld_q) begin
          if (cmp_res.match && !hit_q) begin
            hit_d       = 1'b1;
            hit_exp_d   = cmp_res.expired;
            hit_idx_d   = chk_idx_q;
            hit_cnt_d   = rdata.count;
            hit_start_d = rdata.start;
          end
          if (cmp_res.expired && !exp_q) begin
            exp_d     = 1'b1;
            exp_idx_d = chk_idx_q;
          end
        end
      end
      S_UPD: begin
        state_d = S_DONE;
        if (act_q != pclim_pkg::ACT_RECORD) begin
          res_status_d = hit_q ? pclim_pkg::ST_FOUND : pclim_pkg::ST_NOT_FOUND;
          res_count_d  = hit_q ? hit_cnt_q : '0;
          res_blk_d    = hit_q && (hit_cnt_q >= limit_q);
        end else if (hit_q) begin
          we           = 1'b1;
          waddr        = hit_idx_q;
          if (hit_exp_q) begin
            wdata.count = CW'(1);
          end else begin
            wdata.count = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CW'(1);
          end
          // unexpired: start time is kept
          if (!hit_exp_q) begin
            wdata.start = hit_start_q;
          end
          res_status_d = pclim_pkg::ST_FOUND;
          res_count_d  = wdata.count;
          res_blk_d    = (wdata.count >= limit_q);
        end else if (!full) begin
          we           = 1'b1;
          waddr        = used_q[IW-1:0];
          used_d       = used_q + UW'(1);
          res_status_d = pclim_pkg::ST_NEW;
          res_count_d  = CW'(1);
          res_blk_d    = (CW'(1) >= limit_q);
        end else if (exp_q) begin
          we           = 1'b1;
          waddr        = exp_idx_q;
          res_status_d = pclim_pkg::ST_REUSED;
          res_count_d  = CW'(1);
          res_blk_d    = (CW'(1) >= limit_q);
        end else begin
          res_status_d = pclim_pkg::ST_DROPPED;
          res_count_d  = '0;
          res_blk_d    = 1'b0;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_valid_d = rsp_load || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      chk_vld_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
      window_q    <= pclim_pkg::WINDOW_RESET;
      limit_q     <= pclim_pkg::LIMIT_RESET;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      chk_vld_q   <= chk_vld_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pclim_pkg::CFG_WINDOW: window_q <= cfg_data_i[pclim_pkg::WIN_W-1:0];
          pclim_pkg::CFG_LIMIT:  limit_q  <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      act_q  <= req_i.action;
      host_q <= req_i.host;
      now_q  <= req_i.now_ms;
    end
    rd_idx_q     <= rd_idx_d;
    chk_idx_q    <= chk_idx_d;
    hit_q        <= hit_d;
    hit_exp_q    <= hit_exp_d;
    hit_idx_q    <= hit_idx_d;
    hit_cnt_q    <= hit_cnt_d;
    hit_start_q  <= hit_start_d;
    exp_q        <= exp_d;
    exp_idx_q    <= exp_idx_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_blk_q    <= res_blk_d;
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_count_q  <= res_count_q;
      rsp_blk_q    <= res_blk_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.is_blocked = rsp_blk_q;
  assign rsp_o.host_count = rsp_count_q;

endmodule
